FILE: rtl/core/rgbe_pkg.sv
package rgbe_pkg;

  // Field widths of the configuration port.
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int WIDTH_FIELD_W  = 11;
  localparam int HEIGHT_FIELD_W = 13;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // Output queue depth and its occupancy counter width.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Number of taps in the 3x3 neighborhood.
  localparam int TAPS = 9;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef pixel_t [TAPS-1:0] window_t;

  typedef struct packed {
    pixel_t px;
    logic   frame_end;
  } result_t;

endpackage

FILE: rtl/core/rgbe_line_store.sv
module rgbe_line_store #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rgbe_pkg::pixel_t         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rgbe_pkg::pixel_t         wr_data
);

  rgbe_pkg::pixel_t mem [DEPTH];
  rgbe_pkg::pixel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/rgbe_min9.sv
module rgbe_min9 (
  input  rgbe_pkg::window_t              win,
  input  logic [rgbe_pkg::TAPS-1:0]      mask,
  input  logic                           frame_end,
  output rgbe_pkg::result_t              result
);

  function automatic rgbe_pkg::pixel_t pmin(input rgbe_pkg::pixel_t a,
                                            input rgbe_pkg::pixel_t b);
    rgbe_pkg::pixel_t m;
    m.red   = (a.red   < b.red)   ? a.red   : b.red;
    m.green = (a.green < b.green) ? a.green : b.green;
    m.blue  = (a.blue  < b.blue)  ? a.blue  : b.blue;
    return m;
  endfunction

  rgbe_pkg::window_t v;
  rgbe_pkg::pixel_t  a0, a1, a2, a3, b0, b1, c0;

  // Taps outside the image read as white so they never win the minimum.
  always_comb begin
    for (int i = 0; i < rgbe_pkg::TAPS; i++) begin
      v[i] = mask[i] ? win[i] : '1;
    end
  end

  assign a0 = pmin(v[0], v[1]);
  assign a1 = pmin(v[2], v[3]);
  assign a2 = pmin(v[4], v[5]);
  assign a3 = pmin(v[6], v[7]);
  assign b0 = pmin(a0, a1);
  assign b1 = pmin(a2, a3);
  assign c0 = pmin(b0, b1);

  assign result.px        = pmin(c0, v[8]);
  assign result.frame_end = frame_end;

endmodule

FILE: rtl/core/rgbe_out_fifo.sv
module rgbe_out_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  rgbe_pkg::result_t                 push_data,
  input  logic                              pop,
  output rgbe_pkg::result_t                 head,
  output logic                              not_empty,
  output logic [rgbe_pkg::FIFO_CNT_W-1:0]   count
);

  rgbe_pkg::result_t                 slot_r [rgbe_pkg::FIFO_DEPTH];
  logic [rgbe_pkg::FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rgbe_pkg::FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rgbe_pkg::FIFO_CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head      = slot_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

FILE: rtl/core/rgb_erosion_3x3.sv
// Streaming 3x3 RGB erosion (per-channel minimum filter).
// A result is registered in stages 1 and 2, then queued, after the beat that
// completes its neighborhood, one row plus one pixel after its own pixel.
// Throughput: one beat per cycle while the four-result output queue has room.
// Reset (synchronous, rst_n low) clears positions, window, queue and sets the
// size to 1024 x 768; line stores are not cleared, so no clearing pass runs.
module rgb_erosion_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             cfg_we,
  input  logic [rgbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbe_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_red_min,
  output logic [7:0]                       out_green_min,
  output logic [7:0]                       out_blue_min,
  output logic                             out_frame_end
);

  // Address width of the line stores, width of column counters (they also
  // hold the width itself), width of row counters (the input row runs up to
  // two past the last row while the frame drains), and the priming counter.
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int HT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3);
  localparam int CNT_W = $clog2(MAX_WIDTH + 2);

  // ---------------------------------------------------------------------------
  // Configuration registers. A written value of zero means one, and anything
  // above the maximum saturates. A write to either register restarts the frame.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] width_r, width_nxt;
  logic [HT_W-1:0]  height_r, height_nxt;
  logic [31:0]      cfg_w_val, cfg_h_val;

  always_comb begin
    cfg_w_val  = 32'(cfg_data[rgbe_pkg::WIDTH_FIELD_W-1:0]);
    cfg_h_val  = 32'(cfg_data[rgbe_pkg::HEIGHT_FIELD_W-1:0]);
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rgbe_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_w_val == 32'd0) begin
            width_nxt = COL_W'(1);
          end else if (cfg_w_val > 32'(MAX_WIDTH)) begin
            width_nxt = COL_W'(MAX_WIDTH);
          end else begin
            width_nxt = COL_W'(cfg_w_val);
          end
        end
        rgbe_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_h_val == 32'd0) begin
            height_nxt = HT_W'(1);
          end else if (cfg_h_val > 32'(MAX_HEIGHT)) begin
            height_nxt = HT_W'(MAX_HEIGHT);
          end else begin
            height_nxt = HT_W'(cfg_h_val);
          end
        end
        default: begin
          // Indexes beyond the register list are ignored entirely.
        end
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we && ((cfg_index == rgbe_pkg::REG_IMAGE_WIDTH) ||
                              (cfg_index == rgbe_pkg::REG_IMAGE_HEIGHT));

  // ---------------------------------------------------------------------------
  // Stage 0: input beat. Tracks where the next input pixel and the next result
  // sit in the frame, launches the line store reads, and decides whether this
  // beat releases a result.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [CNT_W-1:0] prime_r, prime_nxt;

  logic             in_fire, take, row_in_frame, emit, fend;
  logic [AW-1:0]    rd_addr;
  rgbe_pkg::pixel_t pix;
  logic [COL_W:0]   col_inc;
  logic [2:0]       col_ok, row_ok;
  logic [rgbe_pkg::TAPS-1:0] mask;
  logic [ROW_W:0]   height_ext;

  assign in_fire      = in_valid && in_ready;
  assign row_in_frame = (in_row_r < ROW_W'(height_r));
  // A flush beat that arrives while pixels are still expected does nothing.
  assign take         = in_fire && !(row_in_frame && in_mode);
  assign rd_addr      = in_col_r[AW-1:0];
  assign col_inc      = {1'b0, in_col_r} + 1'b1;
  assign height_ext   = (ROW_W + 1)'(height_r);

  always_comb begin
    if (row_in_frame) begin
      pix.red   = in_red;
      pix.green = in_green;
      pix.blue  = in_blue;
    end else begin
      // Pixels after the frame's last one act as flush beats.
      pix = '0;
    end
  end

  // The first result needs one row plus two pixels of context.
  assign emit = (prime_r >= (CNT_W'(width_r) + CNT_W'(1)));

  // Which window columns and rows lie inside the image for the next result.
  always_comb begin
    col_ok[0] = (out_col_r != '0);
    col_ok[1] = (out_col_r < width_r);
    col_ok[2] = (({1'b0, out_col_r} + 1'b1) < {1'b0, width_r});
    row_ok[0] = (out_row_r != '0);
    row_ok[1] = ({1'b0, out_row_r} < height_ext);
    row_ok[2] = (({1'b0, out_row_r} + 1'b1) < height_ext);
    for (int dc = 0; dc < 3; dc++) begin
      for (int dr = 0; dr < 3; dr++) begin
        mask[dc*3 + dr] = col_ok[dc] && row_ok[dr];
      end
    end
  end

  assign fend = (out_row_r == ROW_W'(height_r - 1'b1)) &&
                (out_col_r == width_r - 1'b1);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    prime_nxt   = prime_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      prime_nxt   = '0;
    end else if (take) begin
      if (col_inc >= {1'b0, width_r}) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = col_inc[COL_W-1:0];
      end
      if (!emit) begin
        prime_nxt = prime_r + 1'b1;
      end else if (fend) begin
        // Last result of the frame: everything starts over.
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        prime_nxt   = '0;
      end else if (({1'b0, out_col_r} + 1'b1) >= {1'b0, width_r}) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= COL_W'(1024 > MAX_WIDTH ? MAX_WIDTH : 1024);
      height_r  <= HT_W'(768 > MAX_HEIGHT ? MAX_HEIGHT : 768);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      prime_r   <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      prime_r   <= prime_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store data is back. The window shifts left by one column and
  // the stores move down one row at this column. When the width is one, or
  // when a new frame starts right behind the last beat of the previous one,
  // the next beat reads the column this stage is about to write, so the read
  // result is replaced by the values being written.
  // ---------------------------------------------------------------------------
  logic                      s1_valid_r, s1_emit_r, s1_fend_r;
  logic [AW-1:0]             s1_addr_r;
  rgbe_pkg::pixel_t          s1_pix_r;
  logic [rgbe_pkg::TAPS-1:0] s1_mask_r;
  logic                      byp_r;
  rgbe_pkg::pixel_t          byp_up_r, byp_mid_r;
  rgbe_pkg::pixel_t          up_rd, mid_rd, up_eff, mid_eff;

  rgbe_line_store #(.DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (rd_addr),
    .rd_data (up_rd),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (mid_eff)
  );

  rgbe_line_store #(.DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (rd_addr),
    .rd_data (mid_rd),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (s1_pix_r)
  );

  assign up_eff  = byp_r ? byp_up_r  : up_rd;
  assign mid_eff = byp_r ? byp_mid_r : mid_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      s1_valid_r <= take;
      s1_emit_r  <= take && emit;
      byp_r      <= take && s1_valid_r && (s1_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr_r <= rd_addr;
      s1_pix_r  <= pix;
      s1_mask_r <= mask;
      s1_fend_r <= fend;
      byp_up_r  <= mid_eff;
      byp_mid_r <= s1_pix_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the window register feeds the nine-way minimum, whose result is
  // written into the output queue.
  // ---------------------------------------------------------------------------
  rgbe_pkg::window_t         win_r, win_nxt;
  logic                      s2_emit_r, s2_fend_r;
  logic [rgbe_pkg::TAPS-1:0] s2_mask_r;
  rgbe_pkg::result_t         min_res;

  always_comb begin
    win_nxt = win_r;
    if (s1_valid_r) begin
      for (int i = 0; i < 6; i++) begin
        win_nxt[i] = win_r[i + 3];
      end
      win_nxt[6] = up_eff;
      win_nxt[7] = mid_eff;
      win_nxt[8] = s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      s2_emit_r <= 1'b0;
    end else begin
      win_r     <= win_nxt;
      s2_emit_r <= s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit_r) begin
      s2_mask_r <= s1_mask_r;
      s2_fend_r <= s1_fend_r;
    end
  end

  rgbe_min9 u_min9 (
    .win       (win_r),
    .mask      (s2_mask_r),
    .frame_end (s2_fend_r),
    .result    (min_res)
  );

  // ---------------------------------------------------------------------------
  // Output queue. Input beats are taken as long as the queue has room for
  // every result already on its way through stages 1 and 2.
  // ---------------------------------------------------------------------------
  rgbe_pkg::result_t                 head;
  logic [rgbe_pkg::FIFO_CNT_W-1:0]   q_count;
  logic [rgbe_pkg::FIFO_CNT_W-1:0]   pending;
  logic                              out_fire;

  assign out_fire = out_valid && out_ready;

  rgbe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_emit_r),
    .push_data (min_res),
    .pop       (out_fire),
    .head      (head),
    .not_empty (out_valid),
    .count     (q_count)
  );

  assign pending  = q_count + rgbe_pkg::FIFO_CNT_W'(s1_emit_r)
                            + rgbe_pkg::FIFO_CNT_W'(s2_emit_r);
  assign in_ready = (pending < rgbe_pkg::FIFO_CNT_W'(rgbe_pkg::FIFO_DEPTH));

  assign out_red_min   = head.px.red;
  assign out_green_min = head.px.green;
  assign out_blue_min  = head.px.blue;
  assign out_frame_end = head.frame_end;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The credit check on in_ready must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_emit_r && !out_fire) |-> (q_count < rgbe_pkg::FIFO_CNT_W'(rgbe_pkg::FIFO_DEPTH)))
    else $error("output queue overflow");

  // Two beats in a row only share a column at column zero: either the width
  // is one, or a new frame starts right behind the previous one.
  a_bypass_col0: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> (s1_addr_r == '0))
    else $error("line store forwarding away from column zero");

  // The frame's last result returns every position to the frame start.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit && fend && !cfg_we) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 &&
       out_row_r == '0 && prime_r == '0))
    else $error("positions not cleared after frame end");

endmodule

FILE: dv/rgb_erosion_3x3_test.sv
module rgb_erosion_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The input beat type is a single bit, so the two kinds get names here.
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Indexes past the end of the register list. Writes to them must change nothing.
  localparam logic [rgbe_pkg::CFG_IDX_W-1:0] REG_SPARE_LOW  = 2'd2;
  localparam logic [rgbe_pkg::CFG_IDX_W-1:0] REG_SPARE_HIGH = 2'd3;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_H         = 4096;
  localparam int unsigned RANDOM_BEATS  = 300;
  localparam int unsigned SAT_BEATS     = 16;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int          PLAN_LEN      = 30;

  logic                            clk           = 1'b0;
  logic                            rst_n         = 1'b0;
  logic                            cfg_we        = 1'b0;
  logic [rgbe_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [rgbe_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
  logic                            in_valid      = 1'b0;
  logic                            in_ready;
  logic                            in_mode       = MODE_PIXEL;
  logic [7:0]                      in_red        = '0;
  logic [7:0]                      in_green      = '0;
  logic [7:0]                      in_blue       = '0;
  logic                            out_valid;
  logic                            out_ready     = 1'b0;
  logic [7:0]                      out_red_min;
  logic [7:0]                      out_green_min;
  logic [7:0]                      out_blue_min;
  logic                            out_frame_end;

  rgb_erosion_3x3 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red_min  (out_red_min),
    .out_green_min(out_green_min),
    .out_blue_min (out_blue_min),
    .out_frame_end(out_frame_end)
  );

  always #4 clk = ~clk;

  // Shadow copy of the filter state. The line stores start at zero here; in the
  // block they are unknown, but entries that were never written only land in
  // window taps that fall outside the image, so they never reach a minimum.
  rgbe_pkg::pixel_t upper_store  [MAX_W];
  rgbe_pkg::pixel_t middle_store [MAX_W];
  rgbe_pkg::pixel_t taps         [rgbe_pkg::TAPS];
  int unsigned      size_w, size_h;
  int unsigned      in_col, in_row, out_col, out_row;

  // Minima still owed by the block, oldest first.
  rgbe_pkg::result_t awaited_minima [$];
  rgbe_pkg::result_t oldest;

  int unsigned cycle_count   = 0;
  int unsigned errors        = 0;
  int unsigned beats_used    = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_seen   = 0;
  int unsigned reg_writes    = 0;
  bit          quiet         = 1'b0;
  bit          long_hold_req = 1'b0;

  // One row of the directed plan: either a register write or an input beat. A
  // beat row may carry a hand-written expectation that replaces the predicted one.
  typedef enum logic {STEP_CFG, STEP_BEAT} step_kind_t;

  typedef struct packed {
    step_kind_t                      kind;
    logic [rgbe_pkg::CFG_IDX_W-1:0]  idx;
    logic [rgbe_pkg::CFG_DATA_W-1:0] data;
    logic                            mode;
    rgbe_pkg::pixel_t                px;
    logic                            typed;
    rgbe_pkg::result_t               want;
  } plan_row_t;

  plan_row_t plan [PLAN_LEN];

  function automatic plan_row_t cfg_row(logic [rgbe_pkg::CFG_IDX_W-1:0] idx,
                                        logic [rgbe_pkg::CFG_DATA_W-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = STEP_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  function automatic plan_row_t beat_row(logic mode, logic [7:0] r, logic [7:0] g,
                                         logic [7:0] b);
    plan_row_t row;
    row      = '0;
    row.kind = STEP_BEAT;
    row.mode = mode;
    row.px   = '{r, g, b};
    return row;
  endfunction

  // A flush beat that closes a 1x1 frame: its result is the lone pixel itself.
  function automatic plan_row_t closing_row(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    plan_row_t row;
    row       = beat_row(MODE_FLUSH, 8'h00, 8'h00, 8'h00);
    row.typed = 1'b1;
    row.want  = '{'{r, g, b}, 1'b1};
    return row;
  endfunction

  function automatic int unsigned clamp_size(int unsigned v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgbe_pkg::pixel_t random_pixel();
    rgbe_pkg::pixel_t p;
    p.red   = random_level();
    p.green = random_level();
    p.blue  = random_level();
    return p;
  endfunction

  // Any write to a known register restarts the frame; the stores and the window
  // keep whatever they hold.
  task automatic apply_size_write(logic [rgbe_pkg::CFG_IDX_W-1:0] idx,
                                  logic [rgbe_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rgbe_pkg::REG_IMAGE_WIDTH:
        size_w = clamp_size(int'(data[rgbe_pkg::WIDTH_FIELD_W-1:0]), MAX_W);
      rgbe_pkg::REG_IMAGE_HEIGHT:
        size_h = clamp_size(int'(data[rgbe_pkg::HEIGHT_FIELD_W-1:0]), MAX_H);
      default: return;
    endcase
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  // Advances the shadow state by one accepted beat. 'taken' is low when the
  // beat is a flush inside the frame, which the block simply drops.
  task automatic predict_erosion(input logic mode, input rgbe_pkg::pixel_t px,
                                 output bit taken, output bit produced,
                                 output rgbe_pkg::result_t res);
    rgbe_pkg::pixel_t incoming;
    int unsigned      done;
    int               dc, dr, col, row;
    logic [7:0]       rmin, gmin, bmin;
    bit               last;
    taken    = 1'b0;
    produced = 1'b0;
    res      = '0;
    incoming = '0;
    if (in_row < size_h) begin
      if (mode == MODE_FLUSH) return;
      incoming = px;
    end
    taken = 1'b1;

    // Slide the window one column left and bring in the new column.
    for (int i = 0; i < 6; i++) taps[i] = taps[i + 3];
    taps[6]              = upper_store[in_col];
    taps[7]              = middle_store[in_col];
    taps[8]              = incoming;
    upper_store[in_col]  = middle_store[in_col];
    middle_store[in_col] = incoming;

    in_col++;
    if (in_col >= size_w) begin
      in_col = 0;
      in_row++;
    end
    done = in_row * size_w + in_col;
    if (done < size_w + 2) return;

    rmin = 8'hFF;
    gmin = 8'hFF;
    bmin = 8'hFF;
    for (dc = 0; dc < 3; dc++) begin
      col = int'(out_col) + dc - 1;
      if (col < 0 || col >= int'(size_w)) continue;
      for (dr = 0; dr < 3; dr++) begin
        row = int'(out_row) + dr - 1;
        if (row < 0 || row >= int'(size_h)) continue;
        if (taps[dc * 3 + dr].red < rmin) rmin = taps[dc * 3 + dr].red;
        if (taps[dc * 3 + dr].green < gmin) gmin = taps[dc * 3 + dr].green;
        if (taps[dc * 3 + dr].blue < bmin) bmin = taps[dc * 3 + dr].blue;
      end
    end

    last     = (out_row == size_h - 1) && (out_col == size_w - 1);
    res      = '{'{rmin, gmin, bmin}, last};
    produced = 1'b1;
    if (last) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else begin
      out_col++;
      if (out_col >= size_w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // Offers one beat, holding it until the handshake, then records what the
  // block owes for it. Handshakes are sampled at the edge, before any update.
  task automatic send_beat(input logic mode, input rgbe_pkg::pixel_t px, input bit typed,
                           input rgbe_pkg::result_t want);
    bit                taken, produced;
    rgbe_pkg::result_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    do @(posedge clk); while (!in_ready);
    predict_erosion(mode, px, taken, produced, res);
    if (taken) beats_used++;
    if (typed) awaited_minima.push_back(want);
    else if (produced) awaited_minima.push_back(res);
  endtask

  // Registers change only with the block empty. Beats that yield nothing may
  // still be in the pipeline, so a few more cycles pass after the last result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_minima.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rgbe_pkg::CFG_IDX_W-1:0] idx,
                           logic [rgbe_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_size_write(idx, data);
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One frame at the current size: pixels in raster order with the odd stray
  // flush mixed in, then the draining beats, some of which carry a pixel that
  // the block must drop. An abandoned frame stops at a random point and is
  // then cut off by the next register write.
  task automatic send_frame(input bit abandon);
    int unsigned pixels, total, cut, k;
    pixels = size_w * size_h;
    total  = pixels + size_w + 1;
    cut    = abandon ? $urandom_range(1, total - 1) : total;
    for (k = 0; k < cut; k++) begin
      if (k < pixels) begin
        if ($urandom_range(0, 19) == 0) send_beat(MODE_FLUSH, random_pixel(), 1'b0, '0);
        send_beat(MODE_PIXEL, random_pixel(), 1'b0, '0);
      end else begin
        send_beat(($urandom_range(0, 3) == 0) ? MODE_PIXEL : MODE_FLUSH, random_pixel(),
                  1'b0, '0);
      end
    end
  endtask

  // The result side stalls in random bursts, runs freely for stretches, and
  // once holds off for a long time so that the output queue fills and the
  // block has to push back on its input.
  initial begin : result_sink
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 25)) @(posedge clk);
      end
    end
  end

  // Every result beat is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_minima.size() == 0) begin
        $error("result beat with nothing expected: red_min %0d green_min %0d blue_min %0d",
               out_red_min, out_green_min, out_blue_min);
        errors++;
      end else begin
        oldest = awaited_minima.pop_front();
        results_seen++;
        if (oldest.frame_end) frames_seen++;
        if (out_red_min !== oldest.px.red) begin
          $error("red_min: expected %0d, actual %0d", oldest.px.red, out_red_min);
          errors++;
        end
        if (out_green_min !== oldest.px.green) begin
          $error("green_min: expected %0d, actual %0d", oldest.px.green, out_green_min);
          errors++;
        end
        if (out_blue_min !== oldest.px.blue) begin
          $error("blue_min: expected %0d, actual %0d", oldest.px.blue, out_blue_min);
          errors++;
        end
        if (out_frame_end !== oldest.frame_end) begin
          $error("frame_end: expected %0d, actual %0d", oldest.frame_end, out_frame_end);
          errors++;
        end
      end
    end
  end

  // Safety net against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_start, w, h, frames;
    logic [rgbe_pkg::CFG_DATA_W-1:0] wdata, hdata;

    // Shadow state after reset: size 1024 x 768, everything else zero.
    size_w  = 1024;
    size_h  = 768;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
    for (int i = 0; i < rgbe_pkg::TAPS; i++) taps[i] = '0;
    for (int i = 0; i < MAX_W; i++) begin
      upper_store[i]  = '0;
      middle_store[i] = '0;
    end

    // The directed plan. The first part runs 1x1 frames, where each result is
    // simply the one pixel: zero sizes are taken as one, writes past the end of
    // the register list do nothing, a flush ahead of the pixel is dropped, and
    // a pixel sent while draining counts as a flush. The second part is a 3x3
    // frame whose width write carries junk above the field; its minima come
    // from the predictor.
    plan = '{
      cfg_row(rgbe_pkg::REG_IMAGE_WIDTH, 13'd0),
      cfg_row(rgbe_pkg::REG_IMAGE_HEIGHT, 13'd0),
      cfg_row(REG_SPARE_LOW, 13'd7),
      cfg_row(REG_SPARE_HIGH, 13'h1FFF),
      beat_row(MODE_PIXEL, 8'h00, 8'h00, 8'h00),
      beat_row(MODE_FLUSH, 8'h00, 8'h00, 8'h00),
      closing_row(8'h00, 8'h00, 8'h00),
      beat_row(MODE_FLUSH, 8'h12, 8'h34, 8'h56),
      beat_row(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF),
      beat_row(MODE_PIXEL, 8'h00, 8'h00, 8'h00),
      closing_row(8'hFF, 8'hFF, 8'hFF),
      beat_row(MODE_PIXEL, 8'hA5, 8'h5A, 8'h0F),
      beat_row(MODE_FLUSH, 8'hFF, 8'hFF, 8'hFF),
      closing_row(8'hA5, 8'h5A, 8'h0F),
      cfg_row(rgbe_pkg::REG_IMAGE_WIDTH, 13'h0803),
      cfg_row(rgbe_pkg::REG_IMAGE_HEIGHT, 13'd3),
      beat_row(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF),
      beat_row(MODE_PIXEL, 8'h00, 8'hFF, 8'hFF),
      beat_row(MODE_PIXEL, 8'hFF, 8'h80, 8'hFF),
      beat_row(MODE_FLUSH, 8'h00, 8'h00, 8'h00),
      beat_row(MODE_PIXEL, 8'hFF, 8'hFF, 8'h00),
      beat_row(MODE_PIXEL, 8'hC8, 8'h64, 8'h32),
      beat_row(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF),
      beat_row(MODE_PIXEL, 8'h01, 8'h02, 8'h03),
      beat_row(MODE_PIXEL, 8'hFE, 8'hFD, 8'hFC),
      beat_row(MODE_PIXEL, 8'h80, 8'h40, 8'h20),
      beat_row(MODE_FLUSH, 8'h00, 8'h00, 8'h00),
      beat_row(MODE_PIXEL, 8'h00, 8'h00, 8'h00),
      beat_row(MODE_FLUSH, 8'h00, 8'h00, 8'h00),
      beat_row(MODE_FLUSH, 8'h00, 8'h00, 8'h00)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].mode, plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    // Saturating writes take both sizes to their maximum. A few pixels start
    // that frame, and the next write abandons it long before any result is due.
    wait_drained();
    write_reg(rgbe_pkg::REG_IMAGE_WIDTH, 13'h07FF);
    write_reg(rgbe_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
    repeat (SAT_BEATS) send_beat(MODE_PIXEL, random_pixel(), 1'b0, '0);

    // A single-column frame sent while the receiver holds off for a long time.
    // Results come almost at once, so the queue fills quickly and the input
    // stalls while beats keep being offered.
    wait_drained();
    write_reg(rgbe_pkg::REG_IMAGE_WIDTH, 13'd1);
    write_reg(rgbe_pkg::REG_IMAGE_HEIGHT, 13'd48);
    long_hold_req = 1'b1;
    wait (!long_hold_req);
    send_frame(1'b0);

    // Random phases at mostly small sizes. Each phase programs a new size and
    // sends a few frames; now and then the last frame is cut short so that the
    // next write has to abandon it. The final stretch runs with no idling.
    random_start = beats_used;
    while (beats_used - random_start < RANDOM_BEATS) begin
      quiet = (beats_used - random_start) >= RANDOM_BEATS * 4 / 5;
      case ($urandom_range(0, 5))
        0: w = 1;
        1: w = 2;
        2: w = 3;
        3, 4: w = $urandom_range(4, 12);
        default: w = $urandom_range(13, 40);
      endcase
      h = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 5);
      wdata = rgbe_pkg::CFG_DATA_W'(w);
      if ($urandom_range(0, 3) == 0)
        wdata[rgbe_pkg::CFG_DATA_W-1:rgbe_pkg::WIDTH_FIELD_W] = 2'($urandom());
      if (w == 1 && $urandom_range(0, 1) == 0) wdata = '0;
      hdata = rgbe_pkg::CFG_DATA_W'(h);
      if (h == 1 && $urandom_range(0, 1) == 0) hdata = '0;
      wait_drained();
      write_reg(rgbe_pkg::REG_IMAGE_WIDTH, wdata);
      write_reg(rgbe_pkg::REG_IMAGE_HEIGHT, hdata);
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++)
        send_frame(f == frames - 1 && $urandom_range(0, 7) == 0);
    end

    wait_drained();

    $display("Covered %0d input beats and %0d checked results over %0d complete frames,",
             beats_used, results_seen, frames_seen);
    $display("with %0d register writes, saturating sizes, and frames up to 40 x 48.",
             reg_writes);
    if (errors == 0 && awaited_minima.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
